// File: hdl/cxe_pkg.sv
`default_nettype none
package cxe_pkg;

	localparam int unsigned DEPTH   = 1024;
	localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned CNT_W   = 11;
	localparam int unsigned IDX_W   = 32;
	localparam int unsigned TYPE_W  = 16;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_CMPX = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_TYPE  = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_e;

	// last field in the lowest bits
	typedef struct packed {
		logic [WORD_W-1:0] data_value;
		logic [TYPE_W-1:0] order_type;
		logic [IDX_W-1:0]  second_index;
		logic [IDX_W-1:0]  first_index;
		cmd_e              command;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_value;
		logic              swapped;
		status_e           status;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	localparam int unsigned ITEM_W   = $bits(item_t);
	localparam int unsigned RESULT_W = $bits(result_t);
	localparam int unsigned S_DATA_W = ((ITEM_W + 7) / 8) * 8;
	localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

	function automatic logic index_ok(input logic [IDX_W-1:0] idx,
	                                  input logic [CNT_W-1:0] cnt);
		return (idx < {{(IDX_W-CNT_W){1'b0}}, cnt}) && (idx < IDX_W'(DEPTH));
	endfunction

endpackage
`default_nettype wire

// File: hdl/cxe_ram.sv
`default_nettype none
module cxe_ram #(
	parameter int unsigned ADDR_W = 10,
	parameter int unsigned DATA_W = 64,
	parameter int unsigned DEPTH  = 1024
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/cxe_ctrl.sv
`default_nettype none
module cxe_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [cxe_pkg::CNT_W-1:0]     element_count,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire cxe_pkg::item_t                in_item,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output cxe_pkg::result_t                   res,
	output cxe_pkg::ram_req_t                  ram_req,
	input  wire logic [cxe_pkg::WORD_W-1:0]    ram_rdata
);
	import cxe_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD_A = 7'b0000010,
		S_RD_B = 7'b0000100,
		S_CMP  = 7'b0001000,
		S_WR_A = 7'b0010000,
		S_WR_B = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	cmd_e              cmd_q;
	status_e           status_q;
	logic              type_q;
	logic [ADDR_W-1:0] ia_q, ib_q;
	logic [WORD_W-1:0] word_a_q, word_b_q;
	logic              swapped_q;

	logic              accept;
	logic              i_ok, j_ok, bad_type;
	status_e           status_in;
	logic [WORD_W-1:0] cmp_lhs, cmp_rhs;
	logic              need_swap;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_DONE);

	assign i_ok     = index_ok(in_item.first_index, element_count);
	assign j_ok     = index_ok(in_item.second_index, element_count);
	assign bad_type = |in_item.order_type[TYPE_W-1:1];

	always_comb begin
		status_in = ST_OK;
		unique case (in_item.command)
			CMD_LOAD, CMD_READ: begin
				if (!i_ok) status_in = ST_BAD_INDEX;
			end
			CMD_CMPX: begin
				if (bad_type)            status_in = ST_BAD_TYPE;
				else if (!(i_ok && j_ok)) status_in = ST_BAD_INDEX;
			end
			default: status_in = ST_OK;
		endcase
	end

	// single magnitude comparator; operands swapped for descending order
	assign cmp_lhs   = type_q ? word_a_q : ram_rdata;
	assign cmp_rhs   = type_q ? ram_rdata : word_a_q;
	assign need_swap = cmp_lhs < cmp_rhs;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (status_in != ST_OK || in_item.command == CMD_NONE) state_d = S_DONE;
					else if (in_item.command == CMD_LOAD)                 state_d = S_WR_A;
					else                                                   state_d = S_RD_A;
				end
			end
			S_RD_A: state_d = S_RD_B;
			S_RD_B: state_d = (cmd_q == CMD_READ) ? S_DONE : S_CMP;
			S_CMP:  state_d = need_swap ? S_WR_A : S_DONE;
			S_WR_A: state_d = (cmd_q == CMD_LOAD) ? S_DONE : S_WR_B;
			S_WR_B: state_d = S_DONE;
			S_DONE: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			swapped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				swapped_q <= 1'b0;
			end else if (state_q == S_CMP) begin
				swapped_q <= need_swap;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= in_item.command;
			status_q <= status_in;
			type_q   <= in_item.order_type[0];
			ia_q     <= in_item.first_index[ADDR_W-1:0];
			ib_q     <= in_item.second_index[ADDR_W-1:0];
			word_b_q <= in_item.data_value;
		end else if (state_q == S_CMP) begin
			word_b_q <= ram_rdata;
		end
		if (state_q == S_RD_B) begin
			word_a_q <= ram_rdata;
		end
	end

	always_comb begin
		ram_req.we    = (state_q == S_WR_A) || (state_q == S_WR_B);
		ram_req.waddr = (state_q == S_WR_B) ? ib_q : ia_q;
		ram_req.wdata = (state_q == S_WR_B) ? word_a_q : word_b_q;
		ram_req.re    = (state_q == S_RD_A) || (state_q == S_RD_B);
		ram_req.raddr = (state_q == S_RD_B) ? ib_q : ia_q;
	end

	always_comb begin
		res.status     = status_q;
		res.swapped    = swapped_q;
		res.read_value = (cmd_q == CMD_READ && status_q == ST_OK) ? word_a_q : '0;
	end

endmodule
`default_nettype wire

// File: hdl/compare_exchange_array_engine.sv
`default_nettype none
// Compare-exchange engine over a 1024-word store of 64-bit unsigned values.
// Each input item is one command: load a word, compare-exchange two words
// (order type 0 leaves the smaller at the first index, 1 the larger), or
// read a word back. Every item gives exactly one result item with a status
// (ok, bad order type, index out of range), a swapped flag and the read word.
// An index is valid below both element_count and the store depth. The block
// works on one item at a time through a small sequencer and a single-port
// read / single-port write RAM with registered read data. A rejected or
// unused command goes straight to its result, a load writes its word, a read
// reads it, and a compare reads both words, checks them in the one shared
// 64-bit comparator and writes both back only if they must be exchanged. A
// finished result sits in an output register, so the next item is taken while
// it waits. The store has no reset; reading a never-written word returns junk.
// The user must write element_count only while idle; the block does not enforce it.
module compare_exchange_array_engine (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// config
	input  wire logic                             cfg_wen,
	input  wire logic [cxe_pkg::CNT_W-1:0]        cfg_wdata,     // element_count
	// input items
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// command[1:0], first_index[33:2], second_index[65:34],
	// order_type[81:66], data_value[145:82], zero pad above
	input  wire logic [cxe_pkg::S_DATA_W-1:0]     s_tdata,
	// result items
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// status[1:0], swapped[2], read_value[66:3], zero pad above
	output logic [cxe_pkg::M_DATA_W-1:0]          m_tdata
);
	import cxe_pkg::*;

	logic [CNT_W-1:0]  element_count_q;
	item_t             in_item;
	logic              res_valid, res_ready;
	result_t           res;
	ram_req_t          ram_req;
	logic [WORD_W-1:0] ram_rdata;
	logic              m_valid_q;
	result_t           m_res_q;

	// element count register, to be written only between items; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (cfg_wen) begin
			element_count_q <= cfg_wdata;
		end
	end

	assign in_item = s_tdata[ITEM_W-1:0];

	cxe_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.element_count (element_count_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_item       (in_item),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.ram_req       (ram_req),
		.ram_rdata     (ram_rdata)
	);

	cxe_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (WORD_W),
		.DEPTH  (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// output register: frees the sequencer as soon as the slot is free
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_W-RESULT_W){1'b0}}, m_res_q};

	// an accepted item keeps the sequencer busy in the cycle after the accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again straight after an accept");

	// the store is never touched while the sequencer is idle
	a_ram_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.we || ram_req.re) |-> !s_tready)
		else $error("RAM access while idle");

	// one RAM operation per cycle
	a_ram_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ram_req.we, ram_req.re}))
		else $error("RAM read and write in one cycle");

	// an error result never carries a swap or data
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_OK |-> !res.swapped && res.read_value == '0)
		else $error("error result with swap or data");

endmodule
`default_nettype wire

// File: tb/cxe_tb_pkg.sv
package cxe_tb_pkg;

	import cxe_pkg::*;

	// order type codes carried by a compare-exchange item
	localparam logic [TYPE_W-1:0] ORDER_ASC  = 16'd0;
	localparam logic [TYPE_W-1:0] ORDER_DESC = 16'd1;

	class cxe_scoreboard;
		logic [WORD_W-1:0] words [DEPTH];
		logic [CNT_W-1:0]  element_count;
		result_t           awaited_results [$];
		int unsigned       mismatches;
		int unsigned       results_checked;
		int unsigned       exchanges_seen;
		int unsigned       bad_type_seen;
		int unsigned       bad_index_seen;

		function new();
			element_count   = '0;
			mismatches      = 0;
			results_checked = 0;
			exchanges_seen  = 0;
			bad_type_seen   = 0;
			bad_index_seen  = 0;
			foreach (words[k])
				words[k] = '0;
		endfunction

		function void set_element_count(input logic [CNT_W-1:0] cnt);
			element_count = cnt;
		endfunction

		function bit in_range(input logic [IDX_W-1:0] idx);
			return (idx < IDX_W'(element_count)) && (idx < IDX_W'(DEPTH));
		endfunction

		function int unsigned pending();
			return awaited_results.size();
		endfunction

		function void report(input string msg);
			mismatches++;
			$display("MISMATCH %0d: %s", mismatches, msg);
		endfunction

		// work out the result of one accepted command and update the store
		function void note_command(input item_t it);
			result_t           r;
			logic [WORD_W-1:0] a;
			logic [WORD_W-1:0] b;
			bit                need;
			r.status     = ST_OK;
			r.swapped    = 1'b0;
			r.read_value = '0;
			case (it.command)
				CMD_LOAD: begin
					if (in_range(it.first_index))
						words[it.first_index[ADDR_W-1:0]] = it.data_value;
					else
						r.status = ST_BAD_INDEX;
				end
				CMD_CMPX: begin
					if (it.order_type > ORDER_DESC) begin
						r.status = ST_BAD_TYPE;
					end else if (!in_range(it.first_index) || !in_range(it.second_index)) begin
						r.status = ST_BAD_INDEX;
					end else begin
						a    = words[it.first_index[ADDR_W-1:0]];
						b    = words[it.second_index[ADDR_W-1:0]];
						need = (it.order_type == ORDER_ASC) ? (a > b) : (a < b);
						if (need) begin
							words[it.first_index[ADDR_W-1:0]]  = b;
							words[it.second_index[ADDR_W-1:0]] = a;
							r.swapped = 1'b1;
						end
					end
				end
				CMD_READ: begin
					if (in_range(it.first_index))
						r.read_value = words[it.first_index[ADDR_W-1:0]];
					else
						r.status = ST_BAD_INDEX;
				end
				default: ;
			endcase
			awaited_results.push_back(r);
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("result %h arrived with none awaited", got));
				return;
			end
			want = awaited_results.pop_front();
			results_checked++;
			if (want.swapped)
				exchanges_seen++;
			if (want.status == ST_BAD_TYPE)
				bad_type_seen++;
			if (want.status == ST_BAD_INDEX)
				bad_index_seen++;
			if (got.status !== want.status)
				report($sformatf("result %0d status %0d, want %0d",
					results_checked, got.status, want.status));
			if (got.swapped !== want.swapped)
				report($sformatf("result %0d swapped %b, want %b",
					results_checked, got.swapped, want.swapped));
			if (got.read_value !== want.read_value)
				report($sformatf("result %0d read_value %h, want %h",
					results_checked, got.read_value, want.read_value));
		endfunction
	endclass

endpackage

// File: tb/compare_exchange_array_engine_tb.sv
module compare_exchange_array_engine_tb;

	import cxe_pkg::*;
	import cxe_tb_pkg::*;

	localparam int unsigned ITEM_TARGET = 1100;
	localparam int unsigned IDLE_LIMIT  = 3000;  // cycles with no item moving on either side
	localparam int unsigned HOLD_CYCLES = 250;   // long receiver hold-off

	typedef enum int unsigned {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_PATTERN
	} ready_mode_e;

	logic                clk;
	logic                arst_n;
	logic                cfg_wen;
	logic [CNT_W-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;

	cxe_scoreboard sb = new();

	// stimulus-side view of the store: which entries hold a written word,
	// so that no valid read or compare ever touches an unwritten one
	bit          loaded [DEPTH];
	int unsigned cur_count;
	int unsigned items_sent;
	int unsigned burst_left;
	int unsigned settings_used;
	int unsigned sort_runs;
	int unsigned long_holds;
	bit          hold_req;
	bit          gaps_off;

	compare_exchange_array_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// item helpers
	// ---------------------------------------------------------------

	function automatic logic [WORD_W-1:0] rand64();
		logic [WORD_W-1:0] w;
		w[63:32] = $urandom;
		w[31:0]  = $urandom;
		return w;
	endfunction

	// words biased towards the extremes and towards duplicates
	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return WORD_W'($urandom_range(0, 7));
			3:       return rand64() | {1'b1, {(WORD_W-1){1'b0}}};
			default: return rand64();
		endcase
	endfunction

	function automatic int unsigned usable_limit();
		return (cur_count < DEPTH) ? cur_count : DEPTH;
	endfunction

	// an index at or above the usable limit
	function automatic logic [IDX_W-1:0] bad_index();
		int unsigned lim;
		logic [IDX_W-1:0] v;
		lim = usable_limit();
		case ($urandom_range(0, 4))
			0:       v = '1;
			1:       v = IDX_W'(lim);
			2:       v = IDX_W'(DEPTH);
			3:       v = IDX_W'($urandom_range(lim, 32'hFFFF_FFFF));
			default: begin
				v = $urandom;
				if (v < lim)
					v = v + lim;
			end
		endcase
		return v;
	endfunction

	// a valid index that holds a written word; 0 when there is none
	function automatic bit pick_loaded(output logic [IDX_W-1:0] idx);
		int unsigned lim;
		int unsigned start;
		int unsigned k;
		lim = usable_limit();
		idx = '0;
		if (lim == 0)
			return 1'b0;
		for (k = 0; k < 6; k++) begin
			idx = IDX_W'($urandom_range(0, lim - 1));
			if (loaded[idx[ADDR_W-1:0]])
				return 1'b1;
		end
		start = $urandom_range(0, lim - 1);
		for (k = 0; k < lim; k++) begin
			idx = IDX_W'((start + k) % lim);
			if (loaded[idx[ADDR_W-1:0]])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic item_t mk_item(input cmd_e c, input logic [IDX_W-1:0] i,
	                                  input logic [IDX_W-1:0] j,
	                                  input logic [TYPE_W-1:0] t,
	                                  input logic [WORD_W-1:0] v);
		item_t it;
		it.command      = c;
		it.first_index  = i;
		it.second_index = j;
		it.order_type   = t;
		it.data_value   = v;
		return it;
	endfunction

	// ---------------------------------------------------------------
	// driving tasks
	// ---------------------------------------------------------------

	// offer one item, wait for it to be taken, then keep to the burst pattern
	task automatic send_item(input item_t it);
		int unsigned gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'(it);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_command(it);
		items_sent++;
		if (it.command == CMD_LOAD && it.first_index < usable_limit())
			loaded[it.first_index[ADDR_W-1:0]] = 1'b1;
		if (!gaps_off) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = $urandom_range(1, 12);
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
				// now and then a long stretch with no gaps at all
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				                                         : $urandom_range(0, 25);
			end
		end
	endtask

	// sender stops and waits for every awaited result
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic set_element_count(input int unsigned cnt);
		wait_drained();
		repeat (8) @(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= CNT_W'(cnt);
		sb.set_element_count(CNT_W'(cnt));
		cur_count = cnt;
		settings_used++;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// one random command, mostly well formed, some noise
	task automatic random_item();
		logic [IDX_W-1:0]  i;
		logic [IDX_W-1:0]  j;
		logic [TYPE_W-1:0] t;
		int unsigned       r;
		int unsigned       lim;
		lim = usable_limit();
		r   = $urandom_range(0, 99);
		if (r < 30) begin
			if (lim > 0 && $urandom_range(0, 9) != 0)
				i = IDX_W'($urandom_range(0, lim - 1));
			else
				i = bad_index();
			send_item(mk_item(CMD_LOAD, i, $urandom, TYPE_W'($urandom), rand_word()));
		end else if (r < 60) begin
			t = ($urandom_range(0, 9) == 0) ? TYPE_W'($urandom_range(2, 65535))
			                                : TYPE_W'($urandom_range(0, 1));
			if ($urandom_range(0, 7) == 0 || !pick_loaded(i))
				i = bad_index();
			if ($urandom_range(0, 7) == 0)
				j = i;                  // same index on both sides
			else if ($urandom_range(0, 7) == 0 || !pick_loaded(j))
				j = bad_index();
			send_item(mk_item(CMD_CMPX, i, j, t, rand64()));
		end else if (r < 88) begin
			if ($urandom_range(0, 7) == 0 || !pick_loaded(i))
				i = bad_index();
			send_item(mk_item(CMD_READ, i, $urandom, TYPE_W'($urandom), rand64()));
		end else if (r < 94) begin
			// bad order type wins over any index, used or not
			send_item(mk_item(CMD_CMPX, $urandom, $urandom,
				TYPE_W'($urandom_range(2, 65535)), rand64()));
		end else begin
			send_item(mk_item(CMD_NONE, $urandom, $urandom, TYPE_W'($urandom), rand64()));
		end
	endtask

	// load n words, sort them by odd-even transposition, read them back
	task automatic sort_run(input int unsigned n);
		logic [TYPE_W-1:0] dir;
		logic [TYPE_W-1:0] flip;
		bit                narrow;
		int unsigned       k;
		int unsigned       rnd;
		int unsigned       p;
		dir    = $urandom_range(0, 1) ? ORDER_DESC : ORDER_ASC;
		flip   = (dir == ORDER_ASC) ? ORDER_DESC : ORDER_ASC;
		narrow = $urandom_range(0, 1);
		for (k = 0; k < n; k++)
			send_item(mk_item(CMD_LOAD, IDX_W'(k), $urandom, TYPE_W'($urandom),
				narrow ? WORD_W'($urandom_range(0, 7)) : rand_word()));
		for (rnd = 0; rnd < n; rnd++) begin
			for (p = rnd % 2; p + 1 < n; p += 2) begin
				if ($urandom_range(0, 99) < 8)
					random_item();
				// the reversed pair with the opposite order does the same job
				if ($urandom_range(0, 5) == 0)
					send_item(mk_item(CMD_CMPX, IDX_W'(p + 1), IDX_W'(p), flip, rand64()));
				else
					send_item(mk_item(CMD_CMPX, IDX_W'(p), IDX_W'(p + 1), dir, rand64()));
			end
		end
		for (k = 0; k < n; k++)
			send_item(mk_item(CMD_READ, IDX_W'(k), $urandom, TYPE_W'($urandom), rand64()));
		sort_runs++;
	endtask

	// ---------------------------------------------------------------
	// receiver: own stall pattern, plus one long hold-off on request
	// ---------------------------------------------------------------
	initial begin
		ready_mode_e mode;
		int unsigned left;
		int unsigned k;
		int unsigned on_len;
		int unsigned off_len;
		m_tready = 1'b0;
		mode     = RDY_ALWAYS;
		left     = 0;
		k        = 0;
		on_len   = 1;
		off_len  = 1;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				long_holds++;
			end else begin
				if (left == 0) begin
					mode    = ready_mode_e'($urandom_range(0, 2));
					left    = $urandom_range(40, 300);
					on_len  = $urandom_range(1, 6);
					off_len = $urandom_range(1, 5);
					k       = 0;
				end
				left--;
				case (mode)
					RDY_ALWAYS: m_tready <= 1'b1;
					RDY_RANDOM: m_tready <= ($urandom_range(0, 99) < 60);
					default: begin
						m_tready <= (k < on_len);
						k = (k + 1) % (on_len + off_len);
					end
				endcase
			end
		end
	end

	// result monitor: sampled at the rising edge
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				sb.check_result(result_t'(m_tdata[RESULT_W-1:0]));
		end
	end

	// watchdog: ends the run if no item moves for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: nothing moved for %0d cycles, %0d results still awaited",
			IDLE_LIMIT, sb.pending());
		$display("Some tests failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned cnt;
		int unsigned lim;
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_wdata     = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cur_count     = 0;
		items_sent    = 0;
		burst_left    = 0;
		settings_used = 0;
		sort_runs     = 0;
		long_holds    = 0;
		hold_req      = 1'b0;
		gaps_off      = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part; after reset no index is usable
		send_item(mk_item(CMD_LOAD, '0, '0, '0, rand64()));
		send_item(mk_item(CMD_READ, '0, '0, '0, '0));
		send_item(mk_item(CMD_CMPX, '0, '0, ORDER_ASC, '0));
		send_item(mk_item(CMD_CMPX, '0, '0, 16'd2, '0));
		send_item(mk_item(CMD_NONE, '1, '1, '1, '1));

		set_element_count(4);
		send_item(mk_item(CMD_LOAD, 32'd0, '0, '1, 64'd5));      // order type ignored
		send_item(mk_item(CMD_LOAD, 32'd1, '0, '0, '1));
		send_item(mk_item(CMD_LOAD, 32'd2, '0, '0, 64'h8000_0000_0000_0000));
		send_item(mk_item(CMD_LOAD, 32'd3, '0, '0, 64'd5));
		send_item(mk_item(CMD_CMPX, 32'd0, 32'd1, ORDER_DESC, '0));  // exchanges
		send_item(mk_item(CMD_CMPX, 32'd0, 32'd1, ORDER_ASC, '0));   // and back
		send_item(mk_item(CMD_CMPX, 32'd2, 32'd2, ORDER_ASC, '0));   // same index
		send_item(mk_item(CMD_CMPX, 32'd0, 32'd3, ORDER_DESC, '0));  // equal words
		send_item(mk_item(CMD_CMPX, 32'd0, 32'd1, '1, '0));          // bad type
		send_item(mk_item(CMD_CMPX, 32'd4, 32'd0, ORDER_ASC, '0));   // just past count
		send_item(mk_item(CMD_CMPX, '1, 32'd5, 16'd2, '0));          // type checked first
		send_item(mk_item(CMD_READ, '1, '0, '0, '0));
		send_item(mk_item(CMD_READ, 32'd2, '1, '1, '1));

		// count above the depth: the depth bounds the index
		set_element_count(2047);
		send_item(mk_item(CMD_LOAD, 32'd1023, '0, '0, rand64()));
		send_item(mk_item(CMD_READ, 32'd1024, '0, '0, '0));

		set_element_count(1024);
		send_item(mk_item(CMD_CMPX, 32'd1023, 32'd0, ORDER_DESC, '0));
		send_item(mk_item(CMD_READ, 32'd1023, '0, '0, '0));
		send_item(mk_item(CMD_LOAD, 32'd1024, '0, '0, rand64()));

		// random phases, each under its own element_count
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 19))
				0:       cnt = 0;
				1:       cnt = 1;
				2:       cnt = 2;
				3:       cnt = 1024;
				4:       cnt = 2047;
				5:       cnt = $urandom_range(13, 300);
				default: cnt = $urandom_range(3, 12);
			endcase
			set_element_count(cnt);
			lim = usable_limit();
			if (settings_used == 4) begin
				// first random phase: receiver holds off while items keep coming
				hold_req = 1'b1;
				gaps_off = 1'b1;
			end
			if (lim >= 2 && lim <= 12 && $urandom_range(0, 9) < 7)
				sort_run(lim);
			else
				repeat ($urandom_range(20, 60)) random_item();
			gaps_off = 1'b0;
		end

		wait_drained();
		repeat (20) @(negedge clk);

		$display("Run covered %0d items under %0d element_count settings, %0d sorting passes,",
			items_sent, settings_used, sort_runs);
		$display("%0d results checked: %0d exchanges, %0d bad order types, %0d bad indices, %0d long hold-offs",
			sb.results_checked, sb.exchanges_seen, sb.bad_type_seen, sb.bad_index_seen,
			long_holds);
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: compare_exchange_array_engine.f
hdl/cxe_pkg.sv
hdl/cxe_ram.sv
hdl/cxe_ctrl.sv
hdl/compare_exchange_array_engine.sv
tb/cxe_tb_pkg.sv
tb/compare_exchange_array_engine_tb.sv
